FILE: rtl/core/dnd_pkg.sv
`timescale 1ns / 1ps
// dnd_pkg: sizes, codes and state type for the dns name decompressor
// no dependencies

package dnd_pkg;

   localparam int BUFFER_BYTES     = 512;
   localparam int MAX_NAME_CHARS   = 255;
   localparam int MAX_POINTER_HOPS = 16;

   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   localparam int POS_W  = 14;
   localparam int NAME_W = $clog2(MAX_NAME_CHARS + 1);
   localparam int LEN_W  = NAME_W + 1;
   localparam int HOP_W  = $clog2(MAX_POINTER_HOPS + 1);

   localparam logic [POS_W-1:0] BUF_END    = POS_W'(BUFFER_BYTES);
   localparam logic [LEN_W:0]   NAME_LIMIT = (LEN_W + 1)'(MAX_NAME_CHARS);
   localparam logic [HOP_W-1:0] HOP_LIMIT  = HOP_W'(MAX_POINTER_HOPS);

   localparam logic [7:0] PTR_MARK      = 8'hC0;
   localparam logic [7:0] PTR_HIGH_MASK = 8'h3F;
   localparam logic [7:0] LABEL_SEP     = 8'h2E;

   typedef enum logic {
      CMD_STORE  = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_HOPS     = 2'd2,
      STATUS_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_LEN,
      ST_LEN,
      ST_PTR,
      ST_CHAR,
      ST_SEP,
      ST_PACK,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/core/dnd_if.sv
`timescale 1ns / 1ps
// dnd_req_if / dnd_rsp_if: valid/ready channels of the dns name decompressor
// no dependencies

interface dnd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [8:0] address;
   logic [7:0] data_byte;

   modport source (output valid, command, address, data_byte, input ready);
   modport sink (input valid, command, address, data_byte, output ready);
endinterface

interface dnd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] packed_chars;
   logic [3:0]  char_count;
   logic        last;
   logic [1:0]  status;

   modport source (output valid, packed_chars, char_count, last, status, input ready);
   modport sink (input valid, packed_chars, char_count, last, status, output ready);
endinterface

FILE: rtl/core/dns_name_decompressor.sv
`timescale 1ns / 1ps
// dns_name_decompressor: packet byte buffer and label/pointer walking name decoder
// depends on dnd_pkg and dnd_if (dnd_req_if, dnd_rsp_if)

// Usage:
//   req_ch carries commands. A store (command 0) writes data_byte into the
//   packet buffer at address; it gives no item on rsp_ch.
//   A decode (command 1) walks the name at address, following compression
//   pointers, and then sends the dotted name on rsp_ch, up to eight characters per
//   item, the last item marked with last and carrying the status.
//   req_ch.ready is high only while the block is idle; one decode is worked
//   on at a time through the single buffer read port.
//   The walk reads each length byte, follows a pointer through its second
//   byte, and copies each label byte by byte into the name memory with a
//   dot after it. Each result is then gathered from the name memory and
//   offered on rsp_ch.
//   While the receiver stalls, the result stays in the output register; the
//   sequencer waits and nothing is lost.
//   An error ends the walk at once and gives one empty item with its status.
//   Reset (synchronous, active high) returns the sequencer to idle; buffer
//   contents are undefined until written.

module dns_name_decompressor (
   input logic        clock,
   input logic        reset,
   dnd_req_if.sink    req_ch,
   dnd_rsp_if.source  rsp_ch
);

   logic [7:0] store_mem [dnd_pkg::BUFFER_BYTES];
   logic [7:0] name_mem [2**dnd_pkg::NAME_W];

   dnd_pkg::state_type         state_ff, state_in;
   logic [dnd_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [dnd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [dnd_pkg::HOP_W-1:0]  hops_ff, hops_in;
   logic [7:0]                 n_ff, n_in;
   logic [7:0]                 i_ff, i_in;
   logic                       pend_ff, pend_in;
   logic [dnd_pkg::NAME_W-1:0] count_ff, count_in;
   logic [dnd_pkg::LEN_W-1:0]  done_ff, done_in;
   logic [3:0]                 k_ff, k_in;
   dnd_pkg::status_type        status_ff, status_in;
   logic [63:0]                pack_ff, pack_in;
   logic [7:0]                 store_rd_ff;
   logic [7:0]                 name_rd_ff;

   logic                       store_we;
   logic [dnd_pkg::ADDR_W-1:0] store_wa;
   logic [dnd_pkg::POS_W-1:0]  rd_pos;
   logic                       name_we;
   logic [dnd_pkg::NAME_W-1:0] name_wa;
   logic [7:0]                 name_wd;
   logic [dnd_pkg::NAME_W-1:0] name_ra;
   logic [dnd_pkg::LEN_W-1:0]  remain;
   logic [3:0]                 take;
   logic                       is_last;
   logic [dnd_pkg::LEN_W:0]    grown;
   logic [2:0]                 lane;

   assign remain  = dnd_pkg::LEN_W'(count_ff) - done_ff;
   assign take    = (remain > dnd_pkg::LEN_W'(8)) ? 4'd8 : remain[3:0];
   assign is_last = (done_ff + dnd_pkg::LEN_W'(take)) >= dnd_pkg::LEN_W'(count_ff);
   assign grown   = (dnd_pkg::LEN_W + 1)'(len_ff) + (dnd_pkg::LEN_W + 1)'(store_rd_ff);
   assign lane    = 3'(k_ff - 4'd1);

   assign req_ch.ready        = (state_ff == dnd_pkg::ST_IDLE);
   assign rsp_ch.valid        = (state_ff == dnd_pkg::ST_OUT);
   assign rsp_ch.packed_chars = pack_ff;
   assign rsp_ch.char_count   = take;
   assign rsp_ch.last         = is_last;
   assign rsp_ch.status       = is_last ? status_ff : dnd_pkg::STATUS_OK;

   assign store_wa = dnd_pkg::ADDR_W'(req_ch.address);
   assign store_we = req_ch.valid && req_ch.ready
                     && (req_ch.command == dnd_pkg::CMD_STORE)
                     && (dnd_pkg::POS_W'(req_ch.address) < dnd_pkg::BUF_END);

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= req_ch.data_byte;
      end
      store_rd_ff <= store_mem[rd_pos[dnd_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[name_wa] <= name_wd;
      end
      name_rd_ff <= name_mem[name_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dnd_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
         hops_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         hops_ff  <= hops_in;
      end
      pos_ff    <= pos_in;
      len_ff    <= len_in;
      n_ff      <= n_in;
      i_ff      <= i_in;
      count_ff  <= count_in;
      done_ff   <= done_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      pack_ff   <= pack_in;
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      hops_in   = hops_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      pend_in   = pend_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      k_in      = k_ff;
      status_in = status_ff;
      pack_in   = pack_ff;
      rd_pos    = pos_ff;
      name_we   = 1'b0;
      name_wa   = dnd_pkg::NAME_W'(len_ff);
      name_wd   = store_rd_ff;
      name_ra   = dnd_pkg::NAME_W'(done_ff + dnd_pkg::LEN_W'(k_ff));

      unique case (state_ff)
         dnd_pkg::ST_IDLE: begin
            if (req_ch.valid && (req_ch.command == dnd_pkg::CMD_DECODE)) begin
               pos_in    = dnd_pkg::POS_W'(req_ch.address);
               len_in    = '0;
               hops_in   = '0;
               status_in = dnd_pkg::STATUS_OK;
               state_in  = dnd_pkg::ST_RD_LEN;
            end
         end
         dnd_pkg::ST_RD_LEN: begin
            if (pos_ff >= dnd_pkg::BUF_END) begin
               status_in = dnd_pkg::STATUS_RANGE;
               count_in  = '0;
               done_in   = '0;
               k_in      = '0;
               pend_in   = 1'b0;
               pack_in   = '0;
               state_in  = dnd_pkg::ST_PACK;
            end else begin
               state_in = dnd_pkg::ST_LEN;
            end
         end
         dnd_pkg::ST_LEN: begin
            n_in    = store_rd_ff;
            i_in    = '0;
            pend_in = 1'b0;
            done_in = '0;
            k_in    = '0;
            pack_in = '0;
            if (store_rd_ff == 8'd0) begin
               count_in = (len_ff == '0) ? '0 : dnd_pkg::NAME_W'(len_ff - 1'b1);
               state_in = dnd_pkg::ST_PACK;
            end else if ((store_rd_ff & dnd_pkg::PTR_MARK) == dnd_pkg::PTR_MARK) begin
               rd_pos = pos_ff + 1'b1;
               if (rd_pos >= dnd_pkg::BUF_END) begin
                  status_in = dnd_pkg::STATUS_RANGE;
                  count_in  = '0;
                  state_in  = dnd_pkg::ST_PACK;
               end else begin
                  state_in = dnd_pkg::ST_PTR;
               end
            end else if (grown > dnd_pkg::NAME_LIMIT) begin
               status_in = dnd_pkg::STATUS_TOO_LONG;
               count_in  = '0;
               state_in  = dnd_pkg::ST_PACK;
            end else begin
               state_in = dnd_pkg::ST_CHAR;
            end
         end
         dnd_pkg::ST_PTR: begin
            if (hops_ff == dnd_pkg::HOP_LIMIT) begin
               status_in = dnd_pkg::STATUS_HOPS;
               count_in  = '0;
               state_in  = dnd_pkg::ST_PACK;
            end else begin
               hops_in  = hops_ff + 1'b1;
               pos_in   = dnd_pkg::POS_W'({(n_ff & dnd_pkg::PTR_HIGH_MASK), store_rd_ff});
               state_in = dnd_pkg::ST_RD_LEN;
            end
         end
         dnd_pkg::ST_CHAR: begin
            // write the byte read last cycle, issue the next read
            if (pend_ff) begin
               name_we = 1'b1;
               name_wa = dnd_pkg::NAME_W'(len_ff + dnd_pkg::LEN_W'(i_ff) - 1'b1);
               name_wd = store_rd_ff;
            end
            if (i_ff == n_ff) begin
               pend_in  = 1'b0;
               state_in = dnd_pkg::ST_SEP;
            end else begin
               rd_pos = pos_ff + 1'b1 + dnd_pkg::POS_W'(i_ff);
               if (rd_pos >= dnd_pkg::BUF_END) begin
                  status_in = dnd_pkg::STATUS_RANGE;
                  count_in  = '0;
                  pend_in   = 1'b0;
                  state_in  = dnd_pkg::ST_PACK;
               end else begin
                  i_in    = i_ff + 1'b1;
                  pend_in = 1'b1;
               end
            end
         end
         dnd_pkg::ST_SEP: begin
            name_we  = 1'b1;
            name_wa  = dnd_pkg::NAME_W'(len_ff + dnd_pkg::LEN_W'(n_ff));
            name_wd  = dnd_pkg::LABEL_SEP;
            len_in   = len_ff + dnd_pkg::LEN_W'(n_ff) + 1'b1;
            pos_in   = pos_ff + dnd_pkg::POS_W'(n_ff) + 1'b1;
            state_in = dnd_pkg::ST_RD_LEN;
         end
         dnd_pkg::ST_PACK: begin
            // gather up to eight characters, one name memory read a cycle
            if (pend_ff) begin
               pack_in[{lane, 3'b000} +: 8] = name_rd_ff;
            end
            if (k_ff == take) begin
               pend_in  = 1'b0;
               state_in = dnd_pkg::ST_OUT;
            end else begin
               k_in    = k_ff + 1'b1;
               pend_in = 1'b1;
            end
         end
         dnd_pkg::ST_OUT: begin
            if (rsp_ch.ready) begin
               done_in = done_ff + dnd_pkg::LEN_W'(take);
               k_in    = '0;
               pend_in = 1'b0;
               pack_in = '0;
               if (is_last) begin
                  state_in = dnd_pkg::ST_IDLE;
               end else begin
                  state_in = dnd_pkg::ST_PACK;
               end
            end
         end
         default: begin
            state_in = dnd_pkg::ST_IDLE;
         end
      endcase
   end

   a_ready_not_busy : assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("input taken while a result is pending");

   a_status_only_last : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last |-> rsp_ch.status == dnd_pkg::STATUS_OK)
      else $error("error status on a result that is not the last");

   a_error_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != dnd_pkg::STATUS_OK
      |-> rsp_ch.char_count == 4'd0 && rsp_ch.packed_chars == 64'd0)
      else $error("error result carries characters");

   a_hops_bound : assert property (@(posedge clock) disable iff (reset)
      hops_ff <= dnd_pkg::HOP_LIMIT)
      else $error("pointer hop count past its limit");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.char_count))
      else $error("stalled result changed");

endmodule
